// ===== rtl/core/vpsm_pkg.sv =====
// Shared types, constants and codes for the voice pool steal-and-mix unit.
// No dependencies; used by vpsm_alu and voice_pool_steal_and_mix_unit.
package vpsm_pkg;

    // Pool geometry
    localparam int VOICES     = 4;
    localparam int ORDER_BITS = 32;
    localparam int SMP_W      = 16;
    localparam int IDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;

    // Shared adder is wide enough for an order compare or a sample sum
    localparam int ALU_W = ((ORDER_BITS > SMP_W + 1) ? ORDER_BITS : SMP_W + 1) + 1;

    // Mixer clamp limits
    localparam int MIX_MAX_I = 32767;
    localparam int MIX_MIN_I = -32767;

    // Action codes
    localparam logic [1:0] ACT_PLAY = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_MIX  = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]              action;
        logic signed [SMP_W-1:0] sample_voice0;
        logic signed [SMP_W-1:0] sample_voice1;
        logic signed [SMP_W-1:0] sample_voice2;
        logic signed [SMP_W-1:0] sample_voice3;
        logic [3:0]              still_playing;
        logic                    buffer_end;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic signed [SMP_W-1:0] mixed_sample;
        logic [1:0]              chosen_voice;
        logic                    stolen;
        logic [3:0]              active_voices;
    } t_out_item;

    // Shared unit operation
    typedef enum logic {
        ALU_CMP,
        ALU_MIX
    } t_alu_op;

    // Shared unit result
    typedef struct packed {
        logic                    lt;
        logic signed [SMP_W-1:0] sum;
    } t_alu_res;

endpackage

// ===== rtl/core/vpsm_alu.sv =====
// Shared arithmetic unit: one adder that serves the order compare and the
// clamped sample accumulate. Depends on vpsm_pkg.
module vpsm_alu (
    input  vpsm_pkg::t_alu_op             i_op,
    input  logic [vpsm_pkg::ALU_W-1:0]    i_a,
    input  logic [vpsm_pkg::ALU_W-1:0]    i_b,
    output vpsm_pkg::t_alu_res            o_res
);

    localparam int W = vpsm_pkg::ALU_W;
    localparam logic signed [W-1:0] SAT_HI = W'(vpsm_pkg::MIX_MAX_I);
    localparam logic signed [W-1:0] SAT_LO = W'(vpsm_pkg::MIX_MIN_I);

    logic                is_cmp;
    logic [W-1:0]        b_opnd;
    logic [W-1:0]        total;
    logic signed [W-1:0] s_total;

    // Compare is a subtract: a + ~b + 1
    assign is_cmp  = (i_op == vpsm_pkg::ALU_CMP);
    assign b_opnd  = is_cmp ? ~i_b : i_b;
    assign total   = i_a + b_opnd + {{(W-1){1'b0}}, is_cmp};
    assign s_total = signed'(total);

    // Operands of a compare are zero-extended, so the sign flags a borrow
    always_comb begin
        o_res.lt = total[W-1];
        if (s_total > SAT_HI) begin
            o_res.sum = vpsm_pkg::SMP_W'(vpsm_pkg::MIX_MAX_I);
        end else if (s_total < SAT_LO) begin
            o_res.sum = vpsm_pkg::SMP_W'(vpsm_pkg::MIX_MIN_I);
        end else begin
            o_res.sum = s_total[vpsm_pkg::SMP_W-1:0];
        end
    end

endmodule

// ===== rtl/core/voice_pool_steal_and_mix_unit.sv =====
// Voice pool allocator with oldest-voice stealing and a clamped sample mixer.
// Top level; depends on vpsm_pkg and vpsm_alu.
//
// A mix item takes one visit per voice through a single shared add/compare
// unit; a play item visits the voices in index order through the same unit.
// The result then passes to the output register. A play scan ends at the first
// free voice or, with all voices busy, after the last one. Stop and unused
// codes skip the scan and go straight to the output step. The block is back
// in idle when the result loads and takes the next item from there. The input
// stalls while an item is in work. The finished result waits in the output
// register so that the next item can already be taken; a result still held
// there by a stalling receiver keeps the block in its last step. No clearing
// pass is needed after reset.
module voice_pool_steal_and_mix_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  vpsm_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output vpsm_pkg::t_out_item  o_out_item
);

    localparam int NV = vpsm_pkg::VOICES;
    localparam int OB = vpsm_pkg::ORDER_BITS;
    localparam int IW = vpsm_pkg::IDX_W;
    localparam int AW = vpsm_pkg::ALU_W;
    localparam int SW = vpsm_pkg::SMP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLAY,
        S_MIX,
        S_DONE
    } t_state;

    t_state                  r_state;
    vpsm_pkg::t_in_item      r_item;
    vpsm_pkg::t_out_item     r_res;
    vpsm_pkg::t_out_item     r_out_item;
    logic                    r_out_valid;
    logic [IW-1:0]           r_idx;
    logic [IW-1:0]           r_target;
    logic [OB-1:0]           r_best;
    logic signed [SW-1:0]    r_acc;
    logic [NV-1:0]           r_active;
    logic [OB-1:0]           r_order [NV];
    logic [OB-1:0]           r_play_cnt;

    logic signed [SW-1:0]    smp_arr [NV];
    logic [NV-1:0]           still_bits;
    vpsm_pkg::t_alu_op       alu_op;
    logic [AW-1:0]           alu_a;
    logic [AW-1:0]           alu_b;
    vpsm_pkg::t_alu_res      alu_res;
    logic                    idx_last;
    logic                    cur_active;
    logic                    take_this;
    logic [IW-1:0]           win_idx;
    logic [OB-1:0]           n_play_cnt;
    logic signed [SW-1:0]    n_acc;
    logic                    in_take;
    logic                    out_free;

    // Per-voice sample view; voices past the fourth mix in as zero
    always_comb begin
        for (int v = 0; v < NV; v++) begin
            case (v)
                0:       smp_arr[v] = r_item.sample_voice0;
                1:       smp_arr[v] = r_item.sample_voice1;
                2:       smp_arr[v] = r_item.sample_voice2;
                3:       smp_arr[v] = r_item.sample_voice3;
                default: smp_arr[v] = '0;
            endcase
        end
    end

    assign still_bits = NV'(r_item.still_playing);

    // Shared unit operands: order compare while scanning, accumulate while mixing
    always_comb begin
        if (r_state == S_PLAY) begin
            alu_op = vpsm_pkg::ALU_CMP;
            alu_a  = AW'(r_order[r_idx]);
            alu_b  = AW'(r_best);
        end else begin
            alu_op = vpsm_pkg::ALU_MIX;
            alu_a  = AW'(r_acc);
            alu_b  = AW'(smp_arr[r_idx]);
        end
    end

    vpsm_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Scan step decisions
    assign idx_last   = (r_idx == IW'(NV - 1));
    assign cur_active = r_active[r_idx];
    assign take_this  = !cur_active || (r_idx == '0) || alu_res.lt;
    assign win_idx    = take_this ? r_idx : r_target;
    assign n_play_cnt = r_play_cnt + OB'(1);
    assign n_acc      = cur_active ? alu_res.sum : r_acc;

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Sequencer, voice state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            r_play_cnt  <= '0;
            for (int v = 0; v < NV; v++) begin
                r_order[v] <= '0;
            end
        end else begin
            // Output valid: set when a result loads, cleared once it is taken
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_item   <= i_in_item;
                        r_idx    <= '0;
                        r_target <= '0;
                        r_acc    <= '0;
                        r_res    <= '0;
                        unique case (i_in_item.action)
                            vpsm_pkg::ACT_PLAY: r_state <= S_PLAY;
                            vpsm_pkg::ACT_MIX:  r_state <= S_MIX;
                            vpsm_pkg::ACT_STOP: begin
                                r_active <= '0;
                                r_state  <= S_DONE;
                            end
                            default:            r_state <= S_DONE;
                        endcase
                    end
                end

                // Lowest free voice wins; else smallest order, lowest index on a tie
                S_PLAY: begin
                    if (take_this) begin
                        r_target <= r_idx;
                        r_best   <= r_order[r_idx];
                    end
                    if (!cur_active || idx_last) begin
                        r_play_cnt         <= n_play_cnt;
                        r_order[win_idx]   <= n_play_cnt;
                        r_active[win_idx]  <= 1'b1;
                        r_res              <= {r_res.mixed_sample, 2'(win_idx), cur_active,
                                               r_res.active_voices};
                        r_state            <= S_DONE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end

                // Clamped accumulate; finished voices drop at buffer end
                S_MIX: begin
                    r_acc <= n_acc;
                    if (cur_active && r_item.buffer_end && !still_bits[r_idx]) begin
                        r_active[r_idx] <= 1'b0;
                    end
                    if (idx_last) begin
                        r_res.mixed_sample <= n_acc;
                        r_state            <= S_DONE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out_item <= {r_res.mixed_sample, r_res.chosen_voice, r_res.stolen,
                                       4'(r_active)};
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A steal only happens with every voice busy
    a_steal_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.stolen) |-> (&r_active))
        else $error("voice stolen while a voice was free");

    // The play counter moves only when a play request commits
    a_cnt_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_play_cnt)) |-> ($past(r_state) == S_PLAY))
        else $error("play counter moved outside a play scan");

    // Non-mix items report a zero sample
    a_zero_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_item.action != vpsm_pkg::ACT_MIX)
            |-> (r_res.mixed_sample == '0))
        else $error("sample reported for a non-mix item");

    // Clamp never yields the most negative code
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.mixed_sample != 16'sh8000))
        else $error("mixed sample outside clamp range");
`endif

endmodule

// ===== test/voice_mix_checker.sv =====
`timescale 1ns / 100ps
// Checker for the voice pool unit: watches both channels, predicts each result
// from the accepted input items and compares field by field. Depends on vpsm_pkg.
module voice_mix_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  vpsm_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  vpsm_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results_seen,
    output int                  o_play_count,
    output int                  o_stop_count,
    output int                  o_mix_count,
    output int                  o_unused_count,
    output int                  o_steal_count,
    output int                  o_clamp_count,
    output int                  o_release_count
);

    localparam int REPORT_LIMIT = 10;

    // Predicted pool state
    logic [vpsm_pkg::VOICES-1:0]     voice_busy;
    logic [vpsm_pkg::ORDER_BITS-1:0] voice_stamp [vpsm_pkg::VOICES];
    logic [vpsm_pkg::ORDER_BITS-1:0] play_seq;

    // Results still owed by the block, oldest first
    vpsm_pkg::t_out_item owed_results [$];

    int fails;
    int owed_n;
    int seen_n;
    int play_n, stop_n, mix_n, unused_n;
    int steal_n, clamp_n, release_n;

    assign o_fail_count    = fails;
    assign o_pending       = owed_n;
    assign o_results_seen  = seen_n;
    assign o_play_count    = play_n;
    assign o_stop_count    = stop_n;
    assign o_mix_count     = mix_n;
    assign o_unused_count  = unused_n;
    assign o_steal_count   = steal_n;
    assign o_clamp_count   = clamp_n;
    assign o_release_count = release_n;

    // Advance the predicted pool by one item and form its result
    task automatic predict_pool_step(input vpsm_pkg::t_in_item it,
                                     output vpsm_pkg::t_out_item res);
        logic signed [vpsm_pkg::SMP_W-1:0] smp [4];
        int   acc;
        int   pick;
        logic found_free;
        logic clamped;
        smp[0] = it.sample_voice0;
        smp[1] = it.sample_voice1;
        smp[2] = it.sample_voice2;
        smp[3] = it.sample_voice3;
        res = '0;
        case (it.action)
            vpsm_pkg::ACT_PLAY: begin
                play_n++;
                // first free voice wins; otherwise smallest stamp, lowest index on a tie
                pick = -1;
                found_free = 1'b0;
                for (int v = 0; v < vpsm_pkg::VOICES; v++) begin
                    if (!found_free) begin
                        if (!voice_busy[v]) begin
                            pick = v;
                            found_free = 1'b1;
                        end else if (pick < 0 || voice_stamp[v] < voice_stamp[pick]) begin
                            pick = v;
                        end
                    end
                end
                play_seq          = play_seq + 1'b1;
                voice_stamp[pick] = play_seq;
                voice_busy[pick]  = 1'b1;
                res.chosen_voice  = 2'(pick);
                res.stolen        = !found_free;
                if (!found_free) steal_n++;
            end
            vpsm_pkg::ACT_STOP: begin
                stop_n++;
                voice_busy = '0;
            end
            vpsm_pkg::ACT_MIX: begin
                mix_n++;
                acc = 0;
                clamped = 1'b0;
                // clamp after every addition, release finished voices at buffer end
                for (int v = 0; v < vpsm_pkg::VOICES; v++) begin
                    if (voice_busy[v]) begin
                        acc = acc + smp[v];
                        if (acc > vpsm_pkg::MIX_MAX_I) begin
                            acc = vpsm_pkg::MIX_MAX_I;
                            clamped = 1'b1;
                        end else if (acc < vpsm_pkg::MIX_MIN_I) begin
                            acc = vpsm_pkg::MIX_MIN_I;
                            clamped = 1'b1;
                        end
                        if (it.buffer_end && !it.still_playing[v]) begin
                            voice_busy[v] = 1'b0;
                            release_n++;
                        end
                    end
                end
                res.mixed_sample = acc[vpsm_pkg::SMP_W-1:0];
                if (clamped) clamp_n++;
            end
            default: begin
                unused_n++;
            end
        endcase
        res.active_voices = 4'(voice_busy);
    endtask

    // Compare results first: an item taken at this edge cannot answer at the same edge
    always @(posedge i_clk) begin : watch
        vpsm_pkg::t_out_item want;
        vpsm_pkg::t_out_item fresh;
        if (!i_rst_n) begin
            voice_busy = '0;
            for (int v = 0; v < vpsm_pkg::VOICES; v++) voice_stamp[v] = '0;
            play_seq = '0;
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen_n++;
                if (owed_results.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: result with nothing owed", $realtime);
                        $display("    mixed %0d voice %0d stolen %0b active %b",
                                 i_out_item.mixed_sample, i_out_item.chosen_voice,
                                 i_out_item.stolen, i_out_item.active_voices);
                    end
                end else begin
                    want = owed_results.pop_front();
                    if (want !== i_out_item) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: result %0d mismatch", $realtime, seen_n);
                            $display("    mixed_sample  exp %0d got %0d",
                                     want.mixed_sample, i_out_item.mixed_sample);
                            $display("    chosen_voice  exp %0d got %0d",
                                     want.chosen_voice, i_out_item.chosen_voice);
                            $display("    stolen        exp %0b got %0b",
                                     want.stolen, i_out_item.stolen);
                            $display("    active_voices exp %b got %b",
                                     want.active_voices, i_out_item.active_voices);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_pool_step(i_in_item, fresh);
                owed_results.push_back(fresh);
            end
        end
        owed_n = owed_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for voice_pool_steal_and_mix_unit: clock, reset, stimulus and
// verdict. Depends on vpsm_pkg, the unit itself and voice_mix_checker.
module tb_top;

    // Action code the block leaves unassigned
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS  = 520;
    localparam int HOLD_AT      = 150;
    localparam int PAUSE_AT     = 330;
    localparam int CALM_TAIL    = 80;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS   = 3_000_000;

    localparam logic signed [vpsm_pkg::SMP_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [vpsm_pkg::SMP_W-1:0] S_MIN = 16'sh8000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    vpsm_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    vpsm_pkg::t_out_item out_item;

    int fail_count, pending, results_seen;
    int play_count, stop_count, mix_count, unused_count;
    int steal_count, clamp_count, release_count;

    int sent_count   = 0;
    int no_gap_until = 0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;
    bit calm_tail    = 1'b0;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    voice_pool_steal_and_mix_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    voice_mix_checker mix_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (out_item),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results_seen  (results_seen),
        .o_play_count    (play_count),
        .o_stop_count    (stop_count),
        .o_mix_count     (mix_count),
        .o_unused_count  (unused_count),
        .o_steal_count   (steal_count),
        .o_clamp_count   (clamp_count),
        .o_release_count (release_count)
    );

    // Samples lean on the clamp edges
    function automatic logic signed [vpsm_pkg::SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return vpsm_pkg::SMP_W'($urandom);
        endcase
    endfunction

    function automatic vpsm_pkg::t_in_item make_item(
        input logic [1:0]                        act,
        input logic signed [vpsm_pkg::SMP_W-1:0] s0,
        input logic signed [vpsm_pkg::SMP_W-1:0] s1,
        input logic signed [vpsm_pkg::SMP_W-1:0] s2,
        input logic signed [vpsm_pkg::SMP_W-1:0] s3,
        input logic [3:0]                        still,
        input logic                              bend
    );
        vpsm_pkg::t_in_item it;
        it.action        = act;
        it.sample_voice0 = s0;
        it.sample_voice1 = s1;
        it.sample_voice2 = s2;
        it.sample_voice3 = s3;
        it.still_playing = still;
        it.buffer_end    = bend;
        return it;
    endfunction

    function automatic vpsm_pkg::t_in_item make_rand(input logic [1:0] act);
        return make_item(act, pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                         4'($urandom), 1'($urandom));
    endfunction

    // Offer an item after an optional idle burst; returns once taken, or after the pause
    task automatic offer_item(input vpsm_pkg::t_in_item it);
        int gap;
        if (!calm_tail && sent_count >= no_gap_until && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sent_count++;
        // long receiver hold-off while items keep coming back to back
        if (sent_count == HOLD_AT) begin
            hold_req     = 1'b1;
            no_gap_until = sent_count + 24;
        end
        // sender waits for the pool to drain completely
        if (sent_count == PAUSE_AT) begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending != 0) @(negedge clk);
        end
        if (sent_count >= TOTAL_ITEMS - CALM_TAIL) calm_tail = 1'b1;
    endtask

    // Mostly plays followed by one buffer of mixes; some stops, unused codes and noise
    task automatic run_phrase();
        int                 r;
        int                 n;
        vpsm_pkg::t_in_item it;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            offer_item(make_rand(vpsm_pkg::ACT_STOP));
        end else if (r < 10) begin
            offer_item(make_rand(ACT_UNUSED));
        end else if (r < 16) begin
            offer_item(make_rand(2'($urandom_range(0, 3))));
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) offer_item(make_rand(vpsm_pkg::ACT_PLAY));
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
                it = make_rand(vpsm_pkg::ACT_MIX);
                it.buffer_end = (k == n - 1);
                offer_item(it);
            end
        end
    endtask

    // Receiver: random stall bursts, one long hold-off, none in the tail
    initial begin : receiver
        int n;
        forever begin
            if (hold_req && !hold_done) begin
                repeat (LONG_HOLD) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
                hold_done = 1'b1;
            end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end else begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty pool, fill, steal, clamp both ways, release, unused code
        offer_item(make_item(vpsm_pkg::ACT_MIX, S_MAX, S_MAX, S_MAX, S_MAX, 4'h0, 1'b1));
        offer_item(make_item(vpsm_pkg::ACT_STOP, '0, '0, '0, '0, 4'h0, 1'b0));
        repeat (4) offer_item(make_item(vpsm_pkg::ACT_PLAY, '0, '0, '0, '0, 4'h0, 1'b0));
        // full pool: oldest stamps go first, other fields ignored
        offer_item(make_item(vpsm_pkg::ACT_PLAY, S_MIN, S_MIN, S_MIN, S_MIN, 4'hF, 1'b1));
        offer_item(make_item(vpsm_pkg::ACT_PLAY, S_MAX, S_MAX, S_MAX, S_MAX, 4'h0, 1'b1));
        offer_item(make_item(vpsm_pkg::ACT_MIX, S_MAX, S_MAX, S_MAX, S_MAX, 4'hF, 1'b0));
        offer_item(make_item(vpsm_pkg::ACT_MIX, S_MIN, S_MIN, S_MIN, S_MIN, 4'h0, 1'b0));
        offer_item(make_item(vpsm_pkg::ACT_MIX, S_MAX, S_MAX, S_MIN, S_MIN, 4'h3, 1'b0));
        offer_item(make_item(vpsm_pkg::ACT_MIX, 16'sd1, -16'sd1, 16'sd100, -16'sd100,
                             4'h0, 1'b0));
        // buffer end frees voices 1 and 3
        offer_item(make_item(vpsm_pkg::ACT_MIX, 16'sd7, 16'sd9, -16'sd3, 16'sd2, 4'h5, 1'b1));
        offer_item(make_item(ACT_UNUSED, S_MAX, S_MAX, S_MAX, S_MAX, 4'hF, 1'b1));
        offer_item(make_item(vpsm_pkg::ACT_PLAY, '0, '0, '0, '0, 4'h0, 1'b0));
        offer_item(make_item(vpsm_pkg::ACT_MIX, S_MIN, '0, '0, '0, 4'h0, 1'b0));
        offer_item(make_item(vpsm_pkg::ACT_STOP, S_MIN, S_MAX, '1, '0, 4'hA, 1'b1));
        offer_item(make_item(vpsm_pkg::ACT_MIX, S_MAX, S_MAX, S_MAX, S_MAX, 4'h0, 1'b1));
        offer_item(make_item(vpsm_pkg::ACT_PLAY, '0, '0, '0, '0, 4'h0, 1'b0));
        offer_item(make_item(vpsm_pkg::ACT_MIX, S_MIN, S_MAX, S_MAX, S_MAX, 4'hE, 1'b1));
        offer_item(make_item(ACT_UNUSED, '0, '0, '0, '0, 4'h0, 1'b0));
        offer_item(make_item(vpsm_pkg::ACT_PLAY, '0, '0, '0, '0, 4'h0, 1'b0));
        offer_item(make_item(vpsm_pkg::ACT_PLAY, '0, '0, '0, '0, 4'h0, 1'b0));
        offer_item(make_item(vpsm_pkg::ACT_STOP, '0, '0, '0, '0, 4'h0, 1'b0));

        // Random phrases
        while (sent_count < TOTAL_ITEMS) run_phrase();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d items: %0d play, %0d stop, %0d mix, %0d unused code.",
                 sent_count, play_count, stop_count, mix_count, unused_count);
        $display("%0d results checked, %0d steals, %0d clamped sums, %0d buffer-end releases.",
                 results_seen, steal_count, clamp_count, release_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vpsm_pkg.sv
rtl/core/vpsm_alu.sv
rtl/core/voice_pool_steal_and_mix_unit.sv
test/voice_mix_checker.sv
test/tb_top.sv
